@@ design/sddw_pkg.sv @@
// Shared types and constants for the signed decimal digit writer.
package sddw_pkg;

	localparam int MAG_W           = 16;
	localparam int BCD_DIGITS      = 5;
	localparam int BCD_W           = 4 * BCD_DIGITS;
	localparam int STEP_CNT_W      = $clog2(MAG_W);
	localparam int POS_W           = 4;
	localparam int CODE_W          = 4;

	localparam int DIGIT_COUNT_MAX = 6;
	localparam int WRITES_LIMIT    = 6;
	localparam int WRITE_LIMIT     = (DIGIT_COUNT_MAX > WRITES_LIMIT) ? WRITES_LIMIT :
		((DIGIT_COUNT_MAX < 1) ? 1 : DIGIT_COUNT_MAX);

	localparam logic [CODE_W-1:0] MINUS_CODE = 4'hA;

	// Result of one conversion, passed from the converter to the write sequencer.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic             neg;
	} conv_t;

endpackage

@@ design/sddw_dabble.sv @@
// Bit-serial double-dabble converter from signed binary to sign and BCD magnitude.
module sddw_dabble (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [15:0]       number,
	output logic                     conv_valid,
	input  logic                     conv_ready,
	output sddw_pkg::conv_t          conv
);
	import sddw_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] step_q;
	logic [MAG_W-1:0]      mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  neg_q;
	logic [MAG_W-1:0]      mag_in;
	logic [BCD_W-1:0]      bcd_adj;

	// The magnitude of the most negative value still fits in 16 unsigned bits.
	assign mag_in = number[MAG_W-1] ? (~number + 16'd1) : number;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? (bcd_q[4*i +: 4] + 4'd3)
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_CNT_W'(MAG_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (conv_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mag_q <= mag_in;
			neg_q <= number[MAG_W-1];
			bcd_q <= '0;
		end else if (state_q == ST_RUN) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[MAG_W-1]};
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign conv_valid = (state_q == ST_DONE);
	assign conv.bcd   = bcd_q;
	assign conv.neg   = neg_q;

endmodule

@@ design/sddw_emit.sv @@
// Write sequencer that shifts BCD digits out one per word, then the minus code if negative.
module sddw_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   conv_valid,
	output logic                   conv_ready,
	input  sddw_pkg::conv_t        conv,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             digit_position,
	output logic [3:0]             digit_code,
	output logic                   last_write
);
	import sddw_pkg::*;

	logic                 busy_q;
	logic                 first_q;
	logic                 neg_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [POS_W-1:0]     pos_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     pos_out_q;
	logic [CODE_W-1:0]    code_out_q;
	logic                 last_out_q;

	logic                 fire;
	logic                 digit_phase;
	logic [BCD_W-1:0]     bcd_next;
	logic [CODE_W-1:0]    code_now;
	logic                 more;
	logic                 last_now;

	assign fire        = busy_q && (!out_valid_q || out_ready);
	// Digits are sent while any remain; zero still sends its single digit.
	assign digit_phase = first_q || (bcd_q != '0);
	assign bcd_next    = {4'd0, bcd_q[BCD_W-1:4]};
	assign code_now    = digit_phase ? bcd_q[3:0] : MINUS_CODE;
	assign more        = digit_phase && ((bcd_next != '0) || neg_q);
	assign last_now    = !more || (pos_q == POS_W'(WRITE_LIMIT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q && conv_valid) begin
				busy_q <= 1'b1;
			end else if (fire && last_now) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && conv_valid) begin
			bcd_q   <= conv.bcd;
			neg_q   <= conv.neg;
			first_q <= 1'b1;
			pos_q   <= POS_W'(1);
		end else if (fire) begin
			if (digit_phase) begin
				bcd_q <= bcd_next;
			end
			first_q <= 1'b0;
			pos_q   <= pos_q + 1'b1;
		end
		if (fire) begin
			pos_out_q  <= pos_q;
			code_out_q <= code_now;
			last_out_q <= last_now;
		end
	end

	assign conv_ready     = !busy_q;
	assign out_valid      = out_valid_q;
	assign digit_position = pos_out_q;
	assign digit_code     = code_out_q;
	assign last_write     = last_out_q;

endmodule

@@ design/signed_decimal_digit_writer.sv @@
// Top level of the signed decimal digit writer: converter, write sequencer and checks.

// Each accepted number is a signed 16-bit value; the block answers with a run of
// digit-register words for a code-B seven-segment driver, starting at position 1 with
// the least significant decimal digit and moving one position up per word. A negative
// number ends with a word carrying the minus code one position above its top digit, and
// last_write marks the final word of each number. The run never exceeds six words and is
// cut short at the package limit on digit count. On the way to the write sequencer, the
// magnitude is loaded at the accepting edge, then come sixteen double-dabble steps that
// shift one magnitude bit per cycle, and then the handoff of the digits. The sequencer
// then sends one word per cycle while out_ready stays high. The converter takes the next
// number while the previous one is still being written out.
module signed_decimal_digit_writer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         digit_position,
	output logic [3:0]         digit_code,
	output logic               last_write
);
	import sddw_pkg::*;

	logic  conv_valid;
	logic  conv_ready;
	conv_t conv;

	// The converter owns the input handshake and holds its result until the
	// sequencer is free to take it.
	sddw_dabble u_dabble (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.number     (number),
		.conv_valid (conv_valid),
		.conv_ready (conv_ready),
		.conv       (conv)
	);

	// The sequencer drives the output word from a register of its own.
	sddw_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.conv_valid     (conv_valid),
		.conv_ready     (conv_ready),
		.conv           (conv),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digit_position (digit_position),
		.digit_code     (digit_code),
		.last_write     (last_write)
	);

	// A shown word always targets a real position within the limit.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_position >= 4'd1) && (digit_position <= 4'(WRITE_LIMIT)))
		else $error("digit position out of range");

	// Only decimal digits and the minus code are ever sent.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_code <= MINUS_CODE))
		else $error("digit code out of range");

	// The minus sign is always the final word of its number.
	a_minus_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && digit_code == MINUS_CODE) |-> last_write)
		else $error("minus code not on the final word");

	// The converter is busy right after it takes a number.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("converter ready again right after accepting a number");

endmodule
